/* rtl/nps_pkg.sv */
// Shared types and codes of the priority scheduler.
`default_nettype none

package nps_pkg;

  typedef enum logic [1:0] {
    ACT_REGISTER = 2'd0,
    ACT_COMPLETE = 2'd1,
    ACT_TICK     = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STAT_ACCEPTED = 2'd0,
    STAT_DUP      = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_IGNORED  = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_INS_STEP,
    S_INS_PUT,
    S_GNT_RD,
    S_GNT_TAKE,
    S_DONE
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  task_id;
    logic [7:0]  priority_req;
  } req_t;

  typedef struct packed {
    logic        grant_valid;
    logic [7:0]  grant_task;
    logic [7:0]  grant_priority;
    stat_t       status;
    logic [4:0]  queue_count;
    logic        busy_res;
  } res_t;

endpackage

`default_nettype wire

/* rtl/nps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/nps_core.sv */
// Scheduler sequencer: seen map, sorted circular wait queue, run state.
`default_nettype none

module nps_core
  import nps_pkg::*;
#(
  parameter int TASK_IDS    = 256,
  parameter int QUEUE_DEPTH = 16,
  parameter int PRIO_BITS   = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t req,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      res
);

  localparam int ID_W   = (TASK_IDS >= 256) ? 8 : $clog2(TASK_IDS);
  localparam int SEEN_N = (TASK_IDS >= 256) ? 256 : TASK_IDS;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int E_W    = PRIO_BITS + ID_W;

  function automatic logic [ID_W-1:0] id_reduce(input logic [7:0] v);
    logic [31:0] acc;
    logic [31:0] m;
    acc = 32'(v);
    for (int k = 7; k >= 0; k--) begin
      m = 32'(TASK_IDS) << k;
      if (acc >= m) begin
        acc = acc - m;
      end
    end
    return ID_W'(acc);
  endfunction

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [PTR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PTR_W+1)'(QUEUE_DEPTH)) begin
      s = s - (PTR_W+1)'(QUEUE_DEPTH);
    end
    return PTR_W'(s);
  endfunction

  state_t              state, state_next;
  logic [CNT_W-1:0]    count;
  logic [PTR_W-1:0]    head;
  logic [PTR_W-1:0]    jpos;
  logic [ID_W-1:0]     clr_addr;
  logic                started;
  logic                running;
  logic [ID_W-1:0]     running_task;
  action_t             new_act;
  logic [ID_W-1:0]     new_id;
  logic [PRIO_BITS-1:0] new_prio;
  logic                do_grant;
  logic                r_grant;
  logic [7:0]          r_task;
  logic [7:0]          r_prio;
  stat_t               r_status;

  logic                ram_we;
  logic [PTR_W-1:0]    ram_waddr;
  logic [E_W-1:0]      ram_wdata;
  logic [PTR_W-1:0]    ram_raddr;
  logic [E_W-1:0]      ram_rdata;

  logic                seen_we;
  logic [ID_W-1:0]     seen_waddr;
  logic                seen_wdata;
  logic [ID_W-1:0]     seen_raddr;
  logic                seen_rdata;

  action_t             act;
  logic [ID_W-1:0]     in_id;
  logic [PRIO_BITS-1:0] in_prio;
  logic                seen_hit;
  logic                full;
  logic                first;
  logic                match;
  logic                reg_ok;
  logic [CNT_W-1:0]    cnt_m1;
  logic [PRIO_BITS-1:0] rd_prio;
  logic [ID_W-1:0]     rd_id;
  logic                keep;

  nps_ram #(.WIDTH(E_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nps_ram #(.WIDTH(1), .DEPTH(SEEN_N)) u_seen (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (seen_wdata),
    .raddr (seen_raddr),
    .rdata (seen_rdata)
  );

  assign act      = req.action;
  assign in_id    = id_reduce(req.task_id);
  assign in_prio  = PRIO_BITS'(req.priority_req);
  assign seen_hit = seen_rdata;
  assign full     = (count >= CNT_W'(QUEUE_DEPTH));
  assign first    = !started && !running;
  assign match    = running && (running_task == new_id);
  assign reg_ok   = !seen_hit && !full;
  assign cnt_m1   = count - 1'b1;
  assign rd_prio  = ram_rdata[E_W-1:ID_W];
  assign rd_id    = ram_rdata[ID_W-1:0];
  // shared compare: queued entry stays ahead of the new one
  assign keep     = (rd_prio >= new_prio);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == ID_W'(SEEN_N - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
        unique case (new_act)
          ACT_REGISTER: begin
            if (reg_ok) begin
              if (count != '0) begin
                state_next = S_INS_STEP;
              end else if (first) begin
                state_next = S_GNT_RD;
              end
            end
          end
          ACT_COMPLETE: begin
            if (match && count != '0) begin
              state_next = S_GNT_RD;
            end
          end
          ACT_TICK: begin
            if (!running && count != '0) begin
              state_next = S_GNT_RD;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_INS_STEP: begin
        if (keep) begin
          state_next = do_grant ? S_GNT_RD : S_DONE;
        end else if (jpos == '0) begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT:  state_next = do_grant ? S_GNT_RD : S_DONE;
      S_GNT_RD:   state_next = S_GNT_TAKE;
      S_GNT_TAKE: state_next = S_DONE;
      S_DONE: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = head;
    ram_wdata  = {new_prio, new_id};
    ram_raddr  = head;
    seen_we    = 1'b0;
    seen_waddr = new_id;
    seen_wdata = 1'b1;
    seen_raddr = in_id;
    in_ready   = (state == S_IDLE);
    out_valid  = (state == S_DONE);
    unique case (state)
      S_CLEAR: begin
        seen_we    = 1'b1;
        seen_waddr = clr_addr;
        seen_wdata = 1'b0;
      end
      S_DECIDE: begin
        if (new_act == ACT_REGISTER && reg_ok) begin
          seen_we = 1'b1;
          if (count == '0) begin
            ram_we = 1'b1;
          end else begin
            ram_raddr = wrap_add(head, PTR_W'(cnt_m1));
          end
        end
      end
      S_INS_STEP: begin
        ram_we    = 1'b1;
        ram_waddr = wrap_add(head, jpos + 1'b1);
        ram_wdata = keep ? {new_prio, new_id} : ram_rdata;
        if (!keep && jpos != '0) begin
          ram_raddr = wrap_add(head, jpos - 1'b1);
        end
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = head;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      count        <= '0;
      head         <= '0;
      started      <= 1'b0;
      running      <= 1'b0;
      running_task <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: clr_addr <= clr_addr + 1'b1;
        S_IDLE: begin
          if (in_valid) begin
            r_grant  <= 1'b0;
            r_task   <= '0;
            r_prio   <= '0;
            r_status <= STAT_ACCEPTED;
            new_act  <= act;
            new_id   <= in_id;
            new_prio <= in_prio;
            do_grant <= 1'b0;
          end
        end
        S_DECIDE: begin
          jpos <= PTR_W'(cnt_m1);
          unique case (new_act)
            ACT_REGISTER: begin
              if (seen_hit) begin
                r_status <= STAT_DUP;
              end else if (full) begin
                r_status <= STAT_FULL;
              end else begin
                do_grant <= first;
                if (first) begin
                  started <= 1'b1;
                end
                if (count == '0) begin
                  count <= count + 1'b1;
                end
              end
            end
            ACT_COMPLETE: begin
              if (match) begin
                running      <= 1'b0;
                running_task <= '0;
              end else begin
                r_status <= STAT_IGNORED;
              end
            end
            default: ;
          endcase
        end
        S_INS_STEP: begin
          if (keep) begin
            count <= count + 1'b1;
          end else if (jpos != '0) begin
            jpos <= jpos - 1'b1;
          end
        end
        S_INS_PUT: count <= count + 1'b1;
        S_GNT_TAKE: begin
          running      <= 1'b1;
          running_task <= rd_id;
          r_grant      <= 1'b1;
          r_task       <= 8'(rd_id);
          r_prio       <= 8'(rd_prio);
          head         <= wrap_add(head, PTR_W'(1));
          count        <= count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.grant_valid    = r_grant;
    res.grant_task     = r_task;
    res.grant_priority = r_prio;
    res.status         = r_status;
    res.queue_count    = 5'(count);
    res.busy_res       = running;
  end

endmodule

`default_nettype wire

/* rtl/nonpreemptive_priority_scheduler_top.sv */
// Top level of the non-preemptive priority scheduler: stream ports and result register.
// Flow: a word passes S_DECIDE; an insertion moves each queued entry it passes one place
// back in S_INS_STEP, a grant runs S_GNT_RD and S_GNT_TAKE, and S_DONE loads the result
// register. s_tready is high only in S_IDLE, so a new word is taken only once the last
// result has left S_DONE. Reset (rst, synchronous): queue empty, scheduler not started,
// no task running; all min(TASK_IDS, 256) seen-map entries are then cleared with s_tready low.
`default_nettype none

module nonpreemptive_priority_scheduler_top
  import nps_pkg::*;
#(
  parameter int TASK_IDS    = 256,
  parameter int QUEUE_DEPTH = 16,
  parameter int PRIO_BITS   = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // task_id[7:0], priority_req[15:8]
  input  wire logic [1:0]  s_tuser,  // action[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata   // grant_valid[0], grant_task[8:1], grant_priority[16:9],
                                     // status[18:17], queue_count[23:19], busy_res[24]
);

  req_t req;
  res_t res;
  logic core_out_valid;
  logic core_out_ready;

  always_comb begin
    req.action       = action_t'(s_tuser);
    req.task_id      = s_tdata[7:0];
    req.priority_req = s_tdata[15:8];
  end

  assign core_out_ready = !m_tvalid || m_tready;

  nps_core #(
    .TASK_IDS    (TASK_IDS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PRIO_BITS   (PRIO_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .req       (req),
    .out_valid (core_out_valid),
    .out_ready (core_out_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (core_out_valid && core_out_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_out_valid && core_out_ready) begin
      m_tdata <= {7'd0, res.busy_res, res.queue_count, res.status,
                  res.grant_priority, res.grant_task, res.grant_valid};
    end
  end

endmodule

`default_nettype wire
